[design/i2f_pkg.sv]
// Package for the int32 to float32 converter: widths, constants and stage types.
// No dependencies.
`timescale 1ns / 1ps
package i2f_pkg;
    localparam int IntW     = 32;
    localparam int FracW    = 23;
    localparam int PosW     = 5;
    localparam logic [7:0] ExpBias = 8'd127;
    localparam logic [31:0] MinIntBits = 32'hCF00_0000;

    // stage 1 -> stage 2: sign and magnitude
    typedef struct packed {
        logic        vld;
        logic        neg;
        logic        zero;
        logic        minint;
        logic [31:0] mag;
    } s1_t;

    // stage 2 -> stage 3: normalized magnitude and leading-one position
    typedef struct packed {
        logic           vld;
        logic           neg;
        logic           zero;
        logic           minint;
        logic [PosW-1:0] pos;
        logic [31:0]    norm;
    } s2_t;
endpackage

[design/i2f_norm.sv]
// Leading-one detect and normalize shift for the converter (stage 2).
// Depends on i2f_pkg.
`timescale 1ns / 1ps
module i2f_norm
    import i2f_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  s1_t  s1,
    output s2_t  s2
);
    logic [PosW-1:0] pos;
    logic [31:0]     norm;
    logic            vld_reg;
    s2_t             data_reg;

    // find the leading one
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < IntW; i++)
        begin
            if (s1.mag[i])
                pos = PosW'(i);
        end
        norm = s1.mag << (5'(IntW - 1) - pos);
    end

    // advance valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= s1.vld;
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        data_reg.vld    <= 1'b0;
        data_reg.neg    <= s1.neg;
        data_reg.zero   <= s1.zero;
        data_reg.minint <= s1.minint;
        data_reg.pos    <= pos;
        data_reg.norm   <= norm;
    end

    always_comb
    begin
        s2     = data_reg;
        s2.vld = vld_reg;
    end
endmodule

[design/int32_to_float32_converter_top.sv]
// Top level of the int32 to float32 converter.
// Depends on i2f_pkg and i2f_norm.
//
// Usage:
//   Drive int_value and pulse start; a request is taken at every edge where
//   start is high, and busy is tied low, so a request can enter every cycle.
//   Three register stages: sign/magnitude, leading-one normalize, then
//   round and pack. float_bits is shown with done high for exactly one cycle,
//   once the request has passed the sign/magnitude, normalize and output
//   registers in that order. Throughput: one item per cycle.
//   Rounding is to nearest, ties to even; zero gives +0; the most negative
//   integer gives 0xCF000000.
//   Reset clears all valid bits; requests in flight are dropped.
//   The receiver cannot stall: each result is shown for one cycle only.
//   The leading-one search and shift in stage 2 set the stage depth.
`timescale 1ns / 1ps
module int32_to_float32_converter_top
    import i2f_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] int_value,
    output logic        done,
    output logic [31:0] float_bits
);
    logic        s1_vld_reg;
    s1_t         s1_reg;
    s1_t         s1;
    s2_t         s2;
    logic        done_reg;
    logic [31:0] float_reg;
    logic [31:0] float_next;
    logic [23:0] keep;
    logic [24:0] keep_rnd;
    logic        guard;
    logic        sticky;
    logic        rnd_up;
    logic [7:0]  expo;

    assign busy = 1'b0;

    // stage 1: split sign and magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_reg.vld    <= 1'b0;
        s1_reg.neg    <= int_value[31];
        s1_reg.zero   <= (int_value == '0);
        s1_reg.minint <= (int_value == 32'h8000_0000);
        s1_reg.mag    <= int_value[31] ? (32'd0 - int_value) : int_value;
    end

    always_comb
    begin
        s1     = s1_reg;
        s1.vld = s1_vld_reg;
    end

    i2f_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    // stage 3: round to nearest even and pack
    always_comb
    begin
        keep     = s2.norm[31:8];
        guard    = s2.norm[7];
        sticky   = |s2.norm[6:0];
        rnd_up   = guard && (sticky || keep[0]);
        keep_rnd = {1'b0, keep} + 25'(rnd_up);
        expo     = ExpBias + 8'(s2.pos) + 8'(keep_rnd[24]);
        priority if (s2.zero)
            float_next = '0;
        else if (s2.minint)
            float_next = MinIntBits;
        else if (keep_rnd[24])
            float_next = {s2.neg, expo, keep_rnd[23:1]};
        else
            float_next = {s2.neg, expo, keep_rnd[FracW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2.vld;
    end

    always_ff @(posedge clk)
    begin
        float_reg <= float_next;
    end

    assign done       = done_reg;
    assign float_bits = float_reg;

    // each request is followed by a result with done high
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done)
        else $error("result missing");
    // a zero input yields +0
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(s2.zero) |-> float_bits == '0)
        else $error("zero not +0");
    // valid chain is consistent
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        s2.vld |-> $past(s1.vld))
        else $error("valid chain broken");
endmodule

[sim/int32_to_float32_converter_top_test.sv]
// Self-checking testbench for the int32 to float32 converter top level.
// Depends on i2f_pkg and int32_to_float32_converter_top.
`timescale 1ns / 1ps
module int32_to_float32_converter_top_test
    import i2f_pkg::*;
;
    localparam int NumRandom = 1100;
    localparam int PhaseLen  = NumRandom / 4;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] int_value;
    logic        done;
    logic [31:0] float_bits;

    logic [31:0] pending_q[$];
    logic [31:0] float_expected_q[$];
    int          mismatch_count;
    int          idle_pct;

    int32_to_float32_converter_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .int_value(int_value),
        .done(done),
        .float_bits(float_bits)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Convert a signed integer to its single-precision pattern, round to nearest even
    function automatic logic [31:0] convert_to_float(logic [31:0] v);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] keep;
        logic [31:0] drop;
        logic [31:0] half;
        logic [7:0]  expo;
        int          pos;
        int          sh;
        if (v == 32'd0)
            return 32'd0;
        if (v == 32'h8000_0000)
            return MinIntBits;
        neg = v[31];
        mag = neg ? (32'd0 - v) : v;
        pos = 0;
        for (int i = 0; i < 32; i++)
            if (mag[i])
                pos = i;
        expo = ExpBias + 8'(pos);
        if (pos <= FracW)
            keep = mag << (FracW - pos);
        else
        begin
            sh   = pos - FracW;
            keep = mag >> sh;
            drop = mag & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 1);
            if (drop > half || (drop == half && keep[0]))
            begin
                keep = keep + 32'd1;
                if (keep == (32'd1 << (FracW + 1)))
                begin
                    keep = keep >> 1;
                    expo = expo + 8'd1;
                end
            end
        end
        return {neg, expo, keep[FracW-1:0]};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Random value with a random number of significant bits, both signs
    function automatic logic [31:0] random_operand();
        logic [31:0] r;
        int          width;
        r = $urandom;
        width = $urandom_range(32, 1);
        if (width < 32)
            r = r & ((32'd1 << width) - 32'd1);
        if ($urandom_range(1, 0))
            r = 32'd0 - r;
        return r;
    endfunction

    // Driver: issue requests from the pending queue, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            int_value <= 32'd0;
        end
        else
        begin
            if (start && !busy)
                float_expected_q.push_back(convert_to_float(int_value));
            if ((!start || !busy) && pending_q.size() > 0
                && $urandom_range(99, 0) >= idle_pct)
            begin
                start     <= 1'b1;
                int_value <= pending_q.pop_front();
            end
            else if (!start || !busy)
            begin
                start     <= 1'b0;
                int_value <= $urandom;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (float_expected_q.size() == 0)
                report_mismatch("unexpected result", float_bits, 32'd0);
            else
            begin
                if (float_bits !== float_expected_q[0])
                    report_mismatch("float_bits", float_bits, float_expected_q[0]);
                void'(float_expected_q.pop_front());
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAIL int32_to_float32_converter_top");
        $finish;
    end

    initial
    begin
        logic [31:0] directed[$];
        mismatch_count = 0;
        idle_pct       = 0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero, extremes, exact/rounding boundaries, ties, carries
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0001, 32'h00FF_FFFF, 32'h0100_0000, 32'h0100_0001,
                     32'h0100_0003, 32'h0100_0002, 32'h01FF_FFFF, 32'hFE00_0001,
                     32'h0200_0002, 32'h0200_0006, 32'h0200_0003, 32'h0000_0002,
                     32'h0080_0000, 32'h4000_0040, 32'h4000_00C0, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'hFF00_0001, 32'h7FFF_FFC0};
        foreach (directed[i])
            pending_q.push_back(directed[i]);
        wait (pending_q.size() == 0);

        // Random phases: no idling, heavy idling, light idling, none again
        for (int phase = 0; phase < 4; phase++)
        begin
            @(posedge clk);
            idle_pct = (phase == 1) ? 88 : (phase == 2) ? 33 : 0;
            for (int n = 0; n < PhaseLen; n++)
                pending_q.push_back(random_operand());
            wait (pending_q.size() == 0);
        end

        @(posedge clk);
        while (start || float_expected_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && float_expected_q.size() == 0)
            $display("PASS int32_to_float32_converter_top");
        else
            $display("FAIL int32_to_float32_converter_top");
        $finish;
    end
endmodule
